// ----- rtl/stdd_pkg.sv -----
package stdd_pkg;

  // Controller states of the transition gate.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FIND,
    S_WRITE,
    S_OUT
  } state_e;

  // Reasons a proposed change is refused.
  localparam int unsigned CAUSE_BITS = 2;
  localparam logic [CAUSE_BITS-1:0] CAUSE_NONE   = 2'd0;
  localparam logic [CAUSE_BITS-1:0] CAUSE_DWELL  = 2'd1;
  localparam logic [CAUSE_BITS-1:0] CAUSE_REPEAT = 2'd2;

  // Configuration register map.
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned MASK_BITS     = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_DWELL_FAST = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DWELL_SLOW = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN   = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_MASK  = 8'd3;

endpackage

// ----- rtl/state_transition_dwell_dedup_gate_top.sv -----
// State transition gate with minimum dwell and a repeat cooldown. Each request carries a
// proposed state, an optional source id and a nondecreasing timestamp, and produces exactly
// one result: the state in force afterward, whether it changed, the prior state, the time
// spent in the current state and the reason for a refusal. The repeat table is a ring of
// SLOT_COUNT cells that rotates past a single compare unit at its head, one slot per cycle.
// A request that proposes the current state or fails the dwell check goes from the check
// straight to the output state. A request without a source that is accepted spends one
// rotation pruning before its result. A request with a source that passes the dwell check
// first spends one rotation searching for a match, a free slot and the oldest stamp; when
// the repeat check refuses it the result follows, otherwise a second rotation stamps the
// chosen slot and prunes stale entries. One request is in flight at a time; a finished
// result waits in the output register while the next request is already taken.
// Configuration writes are always ready and belong in idle time.
module state_transition_dwell_dedup_gate_top #(
  parameter int unsigned STATE_BITS  = 3,
  parameter int unsigned SLOT_COUNT  = 16,
  parameter int unsigned SOURCE_BITS = 32,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [STATE_BITS-1:0]               proposed_state_i,
  input  logic                                has_source_i,
  input  logic [SOURCE_BITS-1:0]              source_id_i,
  input  logic [TIME_BITS-1:0]                now_time_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [STATE_BITS-1:0]               out_state_o,
  output logic                                changed_o,
  output logic [STATE_BITS-1:0]               prior_state_o,
  output logic [TIME_BITS-1:0]                state_age_o,
  output logic [stdd_pkg::CAUSE_BITS-1:0]     block_cause_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stdd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [stdd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  import stdd_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_e state_q, state_d;

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] dwell_fast_q, dwell_slow_q, cooldown_q;
  logic [MASK_BITS-1:0]     fast_mask_q;

  // Gate state
  logic [STATE_BITS-1:0] cur_q;
  logic [TIME_BITS-1:0]  entered_q;

  // Captured request
  logic [STATE_BITS-1:0]  prop_q;
  logic                   has_src_q;
  logic [SOURCE_BITS-1:0] src_q;
  logic [TIME_BITS-1:0]   now_q;

  // Scan position and search accumulators
  logic [IDX_W-1:0]     idx_q;
  logic                 match_q, block_q, free_q, wr_en_q;
  logic [IDX_W-1:0]     match_idx_q, free_idx_q, min_idx_q, sel_idx_q;
  logic [TIME_BITS-1:0] min_stamp_q;

  // Pending result and output register
  logic [STATE_BITS-1:0] res_state_q, res_prior_q;
  logic                  res_changed_q;
  logic [TIME_BITS-1:0]  res_age_q;
  logic [CAUSE_BITS-1:0] res_cause_q;
  logic                  out_valid_q;
  logic [STATE_BITS-1:0] out_state_q, out_prior_q;
  logic                  out_changed_q;
  logic [TIME_BITS-1:0]  out_age_q;
  logic [CAUSE_BITS-1:0] out_cause_q;

  // Ring of slot cells
  logic                   cell_valid  [SLOT_COUNT];
  logic [SOURCE_BITS-1:0] cell_source [SLOT_COUNT];
  logic [STATE_BITS-1:0]  cell_code   [SLOT_COUNT];
  logic [TIME_BITS-1:0]   cell_stamp  [SLOT_COUNT];
  logic                   head_valid;
  logic [SOURCE_BITS-1:0] head_source;
  logic [STATE_BITS-1:0]  head_code;
  logic [TIME_BITS-1:0]   head_stamp;
  logic                   shift;

  // Control strobes from the state machine
  logic accept, check_go, find_last, load_out;

  // Datapath terms
  logic [TIME_BITS-1:0]  elapsed, age;
  logic [CFG_DATA_BITS-1:0] need;
  logic                  is_fast, dwell_ok;
  logic [TIME_BITS-1:0]  head_diff;
  logic                  head_match, head_cool, head_prune, head_wr;
  logic                  prev_match, prev_block, prev_free;
  logic                  fin_match, fin_block, fin_free, head_less;
  logic [IDX_W-1:0]      fin_match_idx, fin_free_idx, fin_min_idx, sel_idx;
  logic [TIME_BITS-1:0]  fin_min_stamp;
  logic [IDX_W-1:0]      idx_next;

  assign cfg_ready_o = 1'b1;

  // Dwell check and age against the captured timestamp.
  always_comb begin
    elapsed  = now_q - entered_q;
    age      = (entered_q != '0) ? elapsed : '0;
    is_fast  = ({1'b0, cur_q} < (STATE_BITS + 1)'(8)) && fast_mask_q[cur_q[2:0]];
    need     = is_fast ? dwell_fast_q : dwell_slow_q;
    dwell_ok = ((entered_q == '0) && (cur_q == '0)) || (elapsed >= TIME_BITS'(need));
  end

  // Head of the ring: compare, search and the write-back of stamp and prune.
  always_comb begin
    head_diff  = now_q - cell_stamp[0];
    head_match = cell_valid[0] && (cell_source[0] == src_q) && (cell_code[0] == prop_q);
    head_cool  = head_diff < TIME_BITS'(cooldown_q);
    head_prune = {1'b0, head_diff} > (TIME_BITS + 1)'({cooldown_q, 1'b0});
    head_less  = cell_stamp[0] < min_stamp_q;

    prev_match = (idx_q != '0) && match_q;
    prev_block = (idx_q != '0) && block_q;
    prev_free  = (idx_q != '0) && free_q;

    fin_match     = prev_match || head_match;
    fin_match_idx = prev_match ? match_idx_q : idx_q;
    fin_block     = prev_block || (head_match && head_cool);
    fin_free      = prev_free || !cell_valid[0];
    fin_free_idx  = prev_free ? free_idx_q : idx_q;
    if ((idx_q == '0) || head_less) begin
      fin_min_stamp = cell_stamp[0];
      fin_min_idx   = idx_q;
    end else begin
      fin_min_stamp = min_stamp_q;
      fin_min_idx   = min_idx_q;
    end
    sel_idx = fin_match ? fin_match_idx : (fin_free ? fin_free_idx : fin_min_idx);

    head_wr = (state_q == S_WRITE) && wr_en_q && (idx_q == sel_idx_q);
    if (state_q == S_WRITE) begin
      head_valid = head_wr || (cell_valid[0] && !head_prune);
    end else begin
      head_valid = cell_valid[0];
    end
    head_source = head_wr ? src_q  : cell_source[0];
    head_code   = head_wr ? prop_q : cell_code[0];
    head_stamp  = head_wr ? now_q  : cell_stamp[0];

    idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
  end

  assign shift = (state_q == S_FIND) || (state_q == S_WRITE);

  // The ring: each cell takes its neighbor's slot, the last one takes the head's write-back.
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    if (g == SLOT_COUNT - 1) begin : g_last
      stdd_cell #(
        .STATE_BITS (STATE_BITS),
        .SOURCE_BITS(SOURCE_BITS),
        .TIME_BITS  (TIME_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .valid_i (head_valid),
        .source_i(head_source),
        .code_i  (head_code),
        .stamp_i (head_stamp),
        .valid_o (cell_valid[g]),
        .source_o(cell_source[g]),
        .code_o  (cell_code[g]),
        .stamp_o (cell_stamp[g])
      );
    end else begin : g_mid
      stdd_cell #(
        .STATE_BITS (STATE_BITS),
        .SOURCE_BITS(SOURCE_BITS),
        .TIME_BITS  (TIME_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .valid_i (cell_valid[g+1]),
        .source_i(cell_source[g+1]),
        .code_i  (cell_code[g+1]),
        .stamp_i (cell_stamp[g+1]),
        .valid_o (cell_valid[g]),
        .source_o(cell_source[g]),
        .code_o  (cell_code[g]),
        .stamp_o (cell_stamp[g])
      );
    end
  end

  // Next state and strobes.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    check_go   = 1'b0;
    find_last  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        check_go = 1'b1;
        if ((prop_q == cur_q) || !dwell_ok) begin
          state_d = S_OUT;
        end else if (has_src_q) begin
          state_d = S_FIND;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_FIND: begin
        if (idx_q == LAST_IDX) begin
          find_last = 1'b1;
          state_d   = fin_block ? S_OUT : S_WRITE;
        end
      end
      S_WRITE: begin
        if (idx_q == LAST_IDX) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers, gate state, scan position and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_fast_q <= '0;
      dwell_slow_q <= '0;
      cooldown_q   <= '0;
      fast_mask_q  <= '0;
      cur_q        <= '0;
      entered_q    <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DWELL_FAST: dwell_fast_q <= cfg_data_i;
          REG_DWELL_SLOW: dwell_slow_q <= cfg_data_i;
          REG_COOLDOWN:   cooldown_q   <= cfg_data_i;
          REG_FAST_MASK:  fast_mask_q  <= cfg_data_i[MASK_BITS-1:0];
          default: ;
        endcase
      end
      // A change takes effect once the dwell passes and, with a source, no repeat blocks.
      if ((check_go && (prop_q != cur_q) && dwell_ok && !has_src_q) ||
          (find_last && !fin_block)) begin
        cur_q     <= prop_q;
        entered_q <= now_q;
      end
      if (shift) begin
        idx_q <= idx_next;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, search accumulators and the pending result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prop_q    <= proposed_state_i;
      has_src_q <= has_source_i;
      src_q     <= source_id_i;
      now_q     <= now_time_i;
    end
    if (check_go) begin
      res_prior_q <= cur_q;
      wr_en_q     <= 1'b0;
      if ((prop_q != cur_q) && !dwell_ok) begin
        res_state_q   <= cur_q;
        res_changed_q <= 1'b0;
        res_age_q     <= age;
        res_cause_q   <= CAUSE_DWELL;
      end else if ((prop_q != cur_q) && !has_src_q) begin
        res_state_q   <= prop_q;
        res_changed_q <= 1'b1;
        res_age_q     <= '0;
        res_cause_q   <= CAUSE_NONE;
      end else begin
        res_state_q   <= cur_q;
        res_changed_q <= 1'b0;
        res_age_q     <= age;
        res_cause_q   <= CAUSE_NONE;
      end
    end
    if (state_q == S_FIND) begin
      match_q     <= fin_match;
      match_idx_q <= fin_match_idx;
      block_q     <= fin_block;
      free_q      <= fin_free;
      free_idx_q  <= fin_free_idx;
      min_stamp_q <= fin_min_stamp;
      min_idx_q   <= fin_min_idx;
    end
    if (find_last) begin
      if (fin_block) begin
        res_cause_q <= CAUSE_REPEAT;
      end else begin
        res_state_q   <= prop_q;
        res_changed_q <= 1'b1;
        res_age_q     <= '0;
        wr_en_q       <= 1'b1;
        sel_idx_q     <= sel_idx;
      end
    end
    if (load_out) begin
      out_state_q   <= res_state_q;
      out_changed_q <= res_changed_q;
      out_prior_q   <= res_prior_q;
      out_age_q     <= res_age_q;
      out_cause_q   <= res_cause_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_state_o   = out_state_q;
  assign changed_o     = out_changed_q;
  assign prior_state_o = out_prior_q;
  assign state_age_o   = out_age_q;
  assign block_cause_o = out_cause_q;

endmodule

// ----- rtl/stdd_cell.sv -----
module stdd_cell #(
  parameter int unsigned STATE_BITS  = 3,
  parameter int unsigned SOURCE_BITS = 32,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic                   valid_i,
  input  logic [SOURCE_BITS-1:0] source_i,
  input  logic [STATE_BITS-1:0]  code_i,
  input  logic [TIME_BITS-1:0]   stamp_i,
  output logic                   valid_o,
  output logic [SOURCE_BITS-1:0] source_o,
  output logic [STATE_BITS-1:0]  code_o,
  output logic [TIME_BITS-1:0]   stamp_o
);

  logic                   valid_q;
  logic [SOURCE_BITS-1:0] source_q;
  logic [STATE_BITS-1:0]  code_q;
  logic [TIME_BITS-1:0]   stamp_q;

  // The valid flag is cleared by reset; an invalid slot never matches and counts as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  // The slot contents move one cell toward the head on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      source_q <= source_i;
      code_q   <= code_i;
      stamp_q  <= stamp_i;
    end
  end

  assign valid_o  = valid_q;
  assign source_o = source_q;
  assign code_o   = code_q;
  assign stamp_o  = stamp_q;

endmodule
